>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl files; they expect clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMPLIES(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("same-cycle implication violated");

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

>>> rtl/core/rpm_pkg.sv
// shared constants, types and helpers for the row permutation block
`default_nettype none

package rpm_pkg;

  localparam int MAX_PARTS = 64;
  localparam int MAX_ROWS  = 65536;
  localparam int IDX_W     = $clog2(MAX_PARTS);
  localparam int SIDX_W    = $clog2(MAX_PARTS + 1);
  localparam int VAL_W     = 17;
  localparam int PART_W    = 7;
  localparam int KIND_W    = 2;

  // per-part tally saturates at the lesser of the row limit and the value range
  localparam int CAP_INT = (MAX_ROWS < (2 ** VAL_W) - 1) ? MAX_ROWS : (2 ** VAL_W) - 1;
  localparam logic [VAL_W-1:0] COUNT_CAP = VAL_W'(CAP_INT);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_PARTS - 1);

  // transaction kinds
  localparam logic [KIND_W-1:0] KIND_COUNT  = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_ASSIGN = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_READ   = KIND_W'(2);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PFX_RD,
    ST_PFX_WR
  } state_t;

  // sequencer to datapath
  typedef struct packed {
    logic             accept;
    logic             exec;
    logic             pfx_rd;
    logic             pfx_wr;
    logic [IDX_W-1:0] idx;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic done;
    logic to_pfx;
  } exec_stat_t;

  // one result transaction
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic             status;
  } result_t;

  // number of parts actually in use: zero acts as one, large values clip
  function automatic logic [PART_W-1:0] clamp_parts(input logic [PART_W-1:0] n);
    logic [PART_W-1:0] r;
    r = n;
    if (n == '0) r = PART_W'(1);
    else if (n > PART_W'(MAX_PARTS)) r = PART_W'(MAX_PARTS);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/partition_row_permutation.sv
// top level: stable counting-sort row permutation by part id
//
// Input channel in_valid/in_stall carries kind, part and last. Kind 0 counts a
// row in its part, kind 1 hands a row the next free position of its part and
// kind 2 returns a part's start displacement (index num_parts gives the total).
// A count transaction flagged last starts the prefix walk over all 64 parts.
// Result channel out_valid/out_stall carries value and status; status 1 flags
// a part index out of range. Counts in range give no result transaction.
// cfg_we/cfg_wdata write num_parts; the user must do so only while the block
// is idle; the block does not enforce this. Timing: a transaction is accepted
// in idle and executes in the next cycle; its result is then registered in
// the output register and the sequencer returns to idle. After the last
// counted row the prefix walk reads one tally at a time through the single
// tally read port, in a read and a write state per part. in_stall is high
// while busy; a new transaction is still taken while an earlier result waits.
// If the output is stalled when a result is ready, execution holds until the
// output register frees up. Reset clears the tallies through valid bits (no
// clearing pass), sets num_parts to 1 and marks the sums not ready.
`default_nettype none

module partition_row_permutation
  import rpm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [PART_W-1:0] in_part,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [VAL_W-1:0]       out_value,
  output logic                   out_status,
  input  wire logic              cfg_we,
  input  wire logic [PART_W-1:0] cfg_wdata
);

  logic [PART_W-1:0] num_parts_r;
  logic [PART_W-1:0] np;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_value_r;
  logic              out_status_r;
  logic              out_free;
  ctrl_t             ctrl;
  exec_stat_t        stat;
  result_t           res;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) num_parts_r <= PART_W'(1);
    else if (cfg_we) num_parts_r <= cfg_wdata;
  end

  assign np = clamp_parts(num_parts_r);

  // sequencer
  rpm_fsm u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  // datapath
  rpm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_kind  (in_kind),
    .in_part  (in_part),
    .in_last  (in_last),
    .np       (np),
    .out_free (out_free),
    .ctrl     (ctrl),
    .stat     (stat),
    .res      (res)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (res.valid) out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_value_r  <= res.value;
      out_status_r <= res.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

>>> rtl/core/rpm_fsm.sv
// sequencer: item execution and the prefix walk over all parts
`default_nettype none
`include "assert_macros.svh"

module rpm_fsm
  import rpm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire exec_stat_t stat,
  output ctrl_t           ctrl,
  output logic            in_stall
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // state and walk index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.done) begin
          if (stat.to_pfx) state_nxt = ST_PFX_RD;
          else state_nxt = ST_IDLE;
        end
      end
      ST_PFX_RD: begin
        state_nxt = ST_PFX_WR;
      end
      ST_PFX_WR: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
          idx_nxt   = '0;
        end else begin
          state_nxt = ST_PFX_RD;
          idx_nxt   = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctrl.accept = (state_r == ST_IDLE) && in_valid;
    ctrl.exec   = (state_r == ST_EXEC);
    ctrl.pfx_rd = (state_r == ST_PFX_RD);
    ctrl.pfx_wr = (state_r == ST_PFX_WR);
    ctrl.idx    = idx_r;
    in_stall    = (state_r != ST_IDLE);
  end

  // an accepted transaction always goes to execution next
  `ASSERT_NEXT(a_accept_exec, ctrl.accept, state_r == ST_EXEC)
  // the walk ends after the last part and returns to idle
  `ASSERT_NEXT(a_walk_end, ctrl.pfx_wr && (idx_r == LAST_IDX), state_r == ST_IDLE)
  // the walk index only moves inside the walk
  `ASSERT_NEXT(a_idx_rest, state_r == ST_IDLE, idx_r == '0)

endmodule

`default_nettype wire

>>> rtl/core/rpm_dp.sv
// datapath: tally, slot and start memories around one shared 17-bit adder
`default_nettype none
`include "assert_macros.svh"

module rpm_dp
  import rpm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [PART_W-1:0] in_part,
  input  wire logic              in_last,
  input  wire logic [PART_W-1:0] np,
  input  wire logic              out_free,
  input  wire ctrl_t             ctrl,
  output exec_stat_t             stat,
  output result_t                res
);

  // memories
  logic [VAL_W-1:0] cnt_mem_r   [MAX_PARTS];
  logic [VAL_W-1:0] slot_mem_r  [MAX_PARTS];
  logic [VAL_W-1:0] start_mem_r [MAX_PARTS+1];

  logic [VAL_W-1:0]     cnt_rd_r, slot_rd_r, start_rd_r;
  logic [MAX_PARTS-1:0] cnt_vld_r;
  logic                 sums_ready_r;
  logic [VAL_W-1:0]     sum_r;
  logic [KIND_W-1:0]    kind_r;
  logic [PART_W-1:0]    part_r;
  logic                 last_r;

  logic [IDX_W-1:0]  part_idx, cnt_vidx, cnt_raddr, slot_waddr;
  logic [SIDX_W-1:0] start_waddr;
  logic [VAL_W-1:0]  cnt_val, add_a, add_b, sum, slot_wdata, start_wdata;
  logic              cnt_re, start_re, cnt_we, slot_we, start_we;
  logic              in_rng, rd_rng, has_res, cnt_wr_ok, slot_wr_ok, done;
  logic [VAL_W-1:0]  res_value;
  logic              res_status;

  assign part_idx = part_r[IDX_W-1:0];

  // transaction fields held for execution
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      kind_r <= in_kind;
      part_r <= in_part;
      last_r <= in_last;
    end
  end

  // tally as seen through its valid bit
  assign cnt_vidx = ctrl.pfx_wr ? ctrl.idx : part_idx;
  assign cnt_val  = cnt_vld_r[cnt_vidx] ? cnt_rd_r : '0;

  // range checks against the parts in use
  assign in_rng = (part_r < np);
  assign rd_rng = (part_r <= np);

  // execution decode
  always_comb begin
    has_res    = 1'b0;
    res_value  = '0;
    res_status = 1'b0;
    cnt_wr_ok  = 1'b0;
    slot_wr_ok = 1'b0;
    case (kind_r)
      KIND_COUNT: begin
        has_res    = !in_rng;
        res_status = !in_rng;
        cnt_wr_ok  = in_rng && (cnt_val < COUNT_CAP);
      end
      KIND_ASSIGN: begin
        has_res = 1'b1;
        if (!in_rng) begin
          res_status = 1'b1;
        end else if (sums_ready_r) begin
          res_value  = slot_rd_r;
          slot_wr_ok = 1'b1;
        end
      end
      KIND_READ: begin
        has_res = 1'b1;
        if (!rd_rng) res_status = 1'b1;
        else if (sums_ready_r) res_value = start_rd_r;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  // a result waits until the output register can take it
  assign done        = ctrl.exec && (!has_res || out_free);
  assign stat.done   = done;
  assign stat.to_pfx = (kind_r == KIND_COUNT) && last_r;
  assign res.valid   = done && has_res;
  assign res.value   = res_value;
  assign res.status  = res_status;

  // shared adder: increment on execution, running sum on the walk
  always_comb begin
    if (ctrl.pfx_wr) begin
      add_a = sum_r;
      add_b = (PART_W'(ctrl.idx) < np) ? cnt_val : '0;
    end else if (kind_r == KIND_ASSIGN) begin
      add_a = slot_rd_r;
      add_b = VAL_W'(1);
    end else begin
      add_a = cnt_val;
      add_b = VAL_W'(1);
    end
  end
  assign sum = add_a + add_b;

  // tally memory
  assign cnt_re    = ctrl.accept || ctrl.pfx_rd;
  assign cnt_raddr = ctrl.accept ? in_part[IDX_W-1:0] : ctrl.idx;
  assign cnt_we    = done && cnt_wr_ok;

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem_r[part_idx] <= sum;
    if (cnt_re) cnt_rd_r <= cnt_mem_r[cnt_raddr];
  end

  // tally valid bits: set on a count, cleared as the walk passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else begin
      if (cnt_we) cnt_vld_r[part_idx] <= 1'b1;
      if (ctrl.pfx_wr) cnt_vld_r[ctrl.idx] <= 1'b0;
    end
  end

  // next free slot memory
  assign slot_we    = (done && slot_wr_ok) || ctrl.pfx_wr;
  assign slot_waddr = ctrl.pfx_wr ? ctrl.idx : part_idx;
  assign slot_wdata = ctrl.pfx_wr ? sum_r : sum;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem_r[slot_waddr] <= slot_wdata;
    if (ctrl.accept) slot_rd_r <= slot_mem_r[in_part[IDX_W-1:0]];
  end

  // start displacement memory, entry zero written at the walk's first step
  assign start_re    = ctrl.accept && (in_part <= PART_W'(MAX_PARTS));
  assign start_we    = (ctrl.pfx_rd && (ctrl.idx == '0)) || ctrl.pfx_wr;
  assign start_waddr = ctrl.pfx_wr ? (SIDX_W'(ctrl.idx) + SIDX_W'(1)) : '0;
  assign start_wdata = ctrl.pfx_wr ? sum : '0;

  always_ff @(posedge clk) begin
    if (start_we) start_mem_r[start_waddr] <= start_wdata;
    if (start_re) start_rd_r <= start_mem_r[in_part[SIDX_W-1:0]];
  end

  // running sum for the walk
  always_ff @(posedge clk) begin
    if (done && stat.to_pfx) sum_r <= '0;
    else if (ctrl.pfx_wr) sum_r <= sum;
  end

  // sums become usable once the walk has finished
  always_ff @(posedge clk) begin
    if (!rst_n) sums_ready_r <= 1'b0;
    else if (ctrl.pfx_wr && (ctrl.idx == LAST_IDX)) sums_ready_r <= 1'b1;
  end

  // results only go out when the output register has room
  `ASSERT_IMPLIES(a_res_room, res.valid, out_free)
  // sums ready only ever rises at the end of a walk
  `ASSERT_IMPLIES(a_ready_rise, $rose(sums_ready_r), $past(ctrl.pfx_wr))
  // no tally is written while the walk runs
  `ASSERT_IMPLIES(a_walk_quiet, ctrl.pfx_rd || ctrl.pfx_wr, !cnt_we)

endmodule

`default_nettype wire
